>>> hdl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants and types for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // per-stage control handed to each pipeline section
   typedef struct packed {
      logic valid;
      logic advance;
   } m3i_ctl_type;

endpackage

`default_nettype wire

>>> hdl/m3i_channels.sv
// ----------------------------------------------------------------------------
// m3i channels
// Valid/ready channels for matrix items and inverse result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface m3i_req_if #(parameter int W = m3i_pkg::ELEM_WIDTH_DEF);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] a00, a01, a02;
   logic signed [W-1:0] a10, a11, a12;
   logic signed [W-1:0] a20, a21, a22;

   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   output ready);
endinterface

interface m3i_rsp_if #(parameter int W = m3i_pkg::ELEM_WIDTH_DEF);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] r00, r01, r02;
   logic signed [W-1:0] r10, r11, r12;
   logic signed [W-1:0] r20, r21, r22;
   logic signed [W-1:0] det_value;
   logic                singular;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   det_value, singular, input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   det_value, singular, output ready);
endinterface

`default_nettype wire

>>> hdl/m3i_cof.sv
// ----------------------------------------------------------------------------
// m3i_cof
// Two-stage cofactor unit: eighteen products, then nine adjugate entries.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_cof #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  m3i_pkg::m3i_ctl_type           ctl,
   input  wire  signed [ELEM_WIDTH-1:0]   mat [9],
   output logic                           adj_valid,
   output logic signed [2*ELEM_WIDTH:0]   adj [9],
   output logic signed [ELEM_WIDTH-1:0]   row0 [3]
);
   import m3i_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int PW = 2 * W;
   localparam int AW = 2 * W + 1;

   // adj[k] = mat[PA]*mat[PB] - mat[SA]*mat[SB]
   localparam int PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int SA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int SB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   logic signed [PW-1:0] pp_in  [9];
   logic signed [PW-1:0] ps_in  [9];
   logic signed [PW-1:0] pp_ff  [9];
   logic signed [PW-1:0] ps_ff  [9];
   logic signed [W-1:0]  r0a_ff [3];
   logic signed [AW-1:0] adj_in [9];
   logic signed [AW-1:0] adj_ff [9];
   logic signed [W-1:0]  r0b_ff [3];
   logic                 v1_ff, v2_ff;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         pp_in[k]  = PW'(mat[PA[k]]) * PW'(mat[PB[k]]);
         ps_in[k]  = PW'(mat[SA[k]]) * PW'(mat[SB[k]]);
         adj_in[k] = AW'(pp_ff[k]) - AW'(ps_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (ctl.advance) begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         pp_ff  <= pp_in;
         ps_ff  <= ps_in;
         r0a_ff <= '{mat[0], mat[1], mat[2]};
         adj_ff <= adj_in;
         r0b_ff <= r0a_ff;
      end
   end

   assign adj_valid = v2_ff;
   assign adj       = adj_ff;
   assign row0      = r0b_ff;

endmodule

`default_nettype wire

>>> hdl/m3i_det.sv
// ----------------------------------------------------------------------------
// m3i_det
// Three-stage determinant: split partial products, term assembly, final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_det #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  m3i_pkg::m3i_ctl_type           ctl,
   input  wire  signed [2*ELEM_WIDTH:0]   adj [9],
   input  wire  signed [ELEM_WIDTH-1:0]   row0 [3],
   output logic                           det_valid,
   output logic signed [3*ELEM_WIDTH+2:0] det,
   output logic signed [2*ELEM_WIDTH:0]   adj_out [9]
);
   import m3i_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int AW = 2 * W + 1;
   localparam int TW = 3 * W + 1;
   localparam int DW = 3 * W + 3;

   logic signed [W:0]    lo_w   [3];
   logic signed [W:0]    hi_w   [3];
   logic signed [AW-1:0] pl_in  [3];
   logic signed [AW-1:0] ph_in  [3];
   logic signed [AW-1:0] pl_ff  [3];
   logic signed [AW-1:0] ph_ff  [3];
   logic signed [TW-1:0] term_in [3];
   logic signed [TW-1:0] term_ff [3];
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det_ff;
   logic signed [AW-1:0] adja_ff [9];
   logic signed [AW-1:0] adjb_ff [9];
   logic signed [AW-1:0] adjc_ff [9];
   logic                 va_ff, vb_ff, vc_ff;

   // first-row cofactors sit at adj[0], adj[3], adj[6]
   always_comb begin
      for (int t = 0; t < 3; t++) begin
         lo_w[t]    = $signed({1'b0, adj[3*t][W-1:0]});
         hi_w[t]    = adj[3*t][AW-1:W];
         pl_in[t]   = AW'(row0[t]) * AW'(lo_w[t]);
         ph_in[t]   = AW'(row0[t]) * AW'(hi_w[t]);
         term_in[t] = (TW'(ph_ff[t]) <<< W) + TW'(pl_ff[t]);
      end
      det_in = DW'(term_ff[0]) + DW'(term_ff[1]) + DW'(term_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (ctl.advance) begin
         va_ff <= ctl.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         term_ff <= term_in;
         det_ff  <= det_in;
         adja_ff <= adj;
         adjb_ff <= adja_ff;
         adjc_ff <= adjb_ff;
      end
   end

   assign det_valid = vc_ff;
   assign det       = det_ff;
   assign adj_out   = adjc_ff;

endmodule

`default_nettype wire

>>> hdl/m3i_div.sv
// ----------------------------------------------------------------------------
// m3i_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_div #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int NUM_WIDTH  = 4 * m3i_pkg::ELEM_WIDTH_DEF,
   parameter int DEN_WIDTH  = 3 * m3i_pkg::ELEM_WIDTH_DEF + 4
) (
   input  wire                           clock,
   input  wire                           reset,
   input  m3i_pkg::m3i_ctl_type          ctl,
   input  wire  [NUM_WIDTH-1:0]          num,
   input  wire  [DEN_WIDTH-1:0]          den,
   input  wire                           neg,
   output logic                          out_valid,
   output logic signed [ELEM_WIDTH-1:0]  quo
);
   import m3i_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int Q  = ELEM_WIDTH;
   localparam int XW = (NUM_WIDTH > DEN_WIDTH + Q) ? NUM_WIDTH : DEN_WIDTH + Q;

   logic [XW-1:0]        rem_ff  [Q+1];
   logic [DEN_WIDTH-1:0] den_ff  [Q+1];
   logic [Q-1:0]         quo_ff  [Q+1];
   logic                 over_ff [Q+1];
   logic                 neg_ff  [Q+1];
   logic                 v_ff    [Q+1];
   logic                 over_in;
   logic [W-1:0]         limit_w;
   logic [W-1:0]         mag_w;
   logic signed [W-1:0]  res_in;
   logic signed [W-1:0]  res_ff;
   logic                 vo_ff;

   // quotient would need more than Q bits
   assign over_in = (XW'(den) << Q) <= XW'(num);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ctl.advance) begin
         v_ff[0] <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         rem_ff[0]  <= XW'(num);
         den_ff[0]  <= den;
         quo_ff[0]  <= '0;
         over_ff[0] <= over_in;
         neg_ff[0]  <= neg;
      end
   end

   for (genvar j = 1; j <= Q; j++) begin : g_step
      localparam int K = Q - j;
      logic [XW:0]   diff_w;
      logic [XW-1:0] rem_in;
      logic [Q-1:0]  quo_in;

      always_comb begin
         diff_w = (XW+1)'(rem_ff[j-1]) - ((XW+1)'(den_ff[j-1]) << K);
         rem_in = rem_ff[j-1];
         quo_in = quo_ff[j-1];
         if (!diff_w[XW]) begin
            rem_in    = diff_w[XW-1:0];
            quo_in[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (ctl.advance) begin
            v_ff[j] <= v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_ff[j-1];
            quo_ff[j]  <= quo_in;
            over_ff[j] <= over_ff[j-1];
            neg_ff[j]  <= neg_ff[j-1];
         end
      end
   end

   // clamp to the signed range, then apply the sign
   always_comb begin
      limit_w = neg_ff[Q] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      mag_w   = (over_ff[Q] || (quo_ff[Q] > limit_w)) ? limit_w : quo_ff[Q];
      res_in  = neg_ff[Q] ? $signed(-mag_w) : $signed(mag_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (ctl.advance) begin
         vo_ff <= v_ff[Q];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vo_ff;
   assign quo       = res_ff;

endmodule

`default_nettype wire

>>> hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Fixed-point 3x3 matrix inverse through the adjugate, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one matrix per item (a00..a22, signed, FRAC_BITS
//   fraction bits); rsp_chan returns r00..r22, det_value and singular.
//   Both are valid/ready; an item moves when valid and ready are high.
//   Throughput: one matrix per cycle, except while a receiver stall holds
//   the pipeline. The divider resolves one quotient bit per stage over
//   ELEM_WIDTH stages, behind two cofactor, three determinant and one
//   setup stage.
//   A singular matrix (exact determinant zero) returns zero entries, a zero
//   det_value and singular high.
//   Reset clears every valid bit; the payload registers are not reset.
//   When the receiver stalls, the result lands in a one-item skid stage and
//   the whole pipeline holds once that is full, so req_chan.ready drops
//   while the skid stage holds an item and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input wire          clock,
   input wire          reset,
   m3i_req_if.sink     req_chan,
   m3i_rsp_if.source   rsp_chan
);
   import m3i_pkg::*;

   localparam int W    = ELEM_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int AW   = 2 * W + 1;
   localparam int DW   = 3 * W + 3;
   localparam int RW   = DW + 1;
   localparam int NW   = ((AW + 2*F + 1 > DW) ? AW + 2*F + 1 : DW) + 1;
   localparam int DENW = DW + 1;
   localparam int LAT  = W + 2;

   typedef struct {
      logic [W-1:0] r [9];
      logic [W-1:0] detv;
      logic         sing;
   } res_type;

   logic                 advance;
   m3i_ctl_type          ctl_w;
   logic signed [W-1:0]  mat  [9];
   logic                 adj_valid;
   logic signed [AW-1:0] adj  [9];
   logic signed [W-1:0]  row0 [3];
   logic                 det_valid;
   logic signed [DW-1:0] det;
   logic signed [AW-1:0] adj_d [9];

   // setup stage
   logic                 negd_w;
   logic [DW-1:0]        magd_w;
   logic [RW-1:0]        rnd_w;
   logic [RW-1:0]        dlim_w;
   logic [W-1:0]         dmag_w;
   logic [NW-1:0]        num_in [9];
   logic [NW-1:0]        num_ff [9];
   logic                 neg_in [9];
   logic                 neg_ff [9];
   logic [DENW-1:0]      den_in;
   logic [DENW-1:0]      den_ff;
   logic                 zero_in, zero_ff;
   logic [W-1:0]         detv_in, detv_ff;
   logic                 pv_ff;

   // divider lanes and side line
   m3i_ctl_type          dctl_w;
   logic signed [W-1:0]  quo [9];
   logic                 div_valid;
   logic                 zero_d_ff [LAT];
   logic [W-1:0]         detv_d_ff [LAT];

   // output and skid
   res_type              res_w;
   res_type              out_ff, out_in;
   res_type              skid_ff, skid_in;
   logic                 out_v_ff, out_v_in;
   logic                 skid_v_ff, skid_v_in;

   // hold the whole pipeline only while the skid stage is occupied
   assign advance        = !skid_v_ff;
   assign req_chan.ready = advance;

   assign mat[0] = req_chan.a00;
   assign mat[1] = req_chan.a01;
   assign mat[2] = req_chan.a02;
   assign mat[3] = req_chan.a10;
   assign mat[4] = req_chan.a11;
   assign mat[5] = req_chan.a12;
   assign mat[6] = req_chan.a20;
   assign mat[7] = req_chan.a21;
   assign mat[8] = req_chan.a22;

   assign ctl_w.valid   = req_chan.valid;
   assign ctl_w.advance = advance;

   m3i_cof #(.ELEM_WIDTH(W)) u_cof (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_w),
      .mat       (mat),
      .adj_valid (adj_valid),
      .adj       (adj),
      .row0      (row0)
   );

   m3i_det #(.ELEM_WIDTH(W)) u_det (
      .clock     (clock),
      .reset     (reset),
      .ctl       ('{valid: adj_valid, advance: advance}),
      .adj       (adj),
      .row0      (row0),
      .det_valid (det_valid),
      .det       (det),
      .adj_out   (adj_d)
   );

   // Setup: magnitudes, rounded and clamped det_value, and per-lane
   // numerators 2*|A|*2^(2F) + |D| over the denominator 2*|D|, so that
   // the truncating divider rounds to nearest, ties away from zero.
   always_comb begin
      negd_w  = det[DW-1];
      magd_w  = negd_w ? DW'(-det) : DW'(det);
      zero_in = (det == '0);
      rnd_w   = (RW'(magd_w) + (RW'(1) << (2*F - 1))) >> (2*F);
      dlim_w  = negd_w ? (RW'(1) << (W - 1)) : ((RW'(1) << (W - 1)) - RW'(1));
      dmag_w  = (rnd_w > dlim_w) ? dlim_w[W-1:0] : rnd_w[W-1:0];
      detv_in = negd_w ? W'(-dmag_w) : dmag_w;
      den_in  = {magd_w, 1'b0};
      for (int k = 0; k < 9; k++) begin
         neg_in[k] = adj_d[k][AW-1] ^ negd_w;
         num_in[k] = (NW'(adj_d[k][AW-1] ? AW'(-adj_d[k]) : AW'(adj_d[k])) << (2*F + 1))
                     + NW'(magd_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (advance) begin
         pv_ff <= det_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff  <= num_in;
         neg_ff  <= neg_in;
         den_ff  <= den_in;
         zero_ff <= zero_in;
         detv_ff <= detv_in;
      end
   end

   assign dctl_w.valid   = pv_ff;
   assign dctl_w.advance = advance;

   for (genvar k = 0; k < 9; k++) begin : g_lane
      if (k == 0) begin : g_lead
         m3i_div #(.ELEM_WIDTH(W), .NUM_WIDTH(NW), .DEN_WIDTH(DENW)) u_div (
            .clock     (clock),
            .reset     (reset),
            .ctl       (dctl_w),
            .num       (num_ff[k]),
            .den       (den_ff),
            .neg       (neg_ff[k]),
            .out_valid (div_valid),
            .quo       (quo[k])
         );
      end else begin : g_rest
         m3i_div #(.ELEM_WIDTH(W), .NUM_WIDTH(NW), .DEN_WIDTH(DENW)) u_div (
            .clock     (clock),
            .reset     (reset),
            .ctl       (dctl_w),
            .num       (num_ff[k]),
            .den       (den_ff),
            .neg       (neg_ff[k]),
            .out_valid (),
            .quo       (quo[k])
         );
      end
   end

   // carry the singular flag and det_value alongside the divider lanes
   always_ff @(posedge clock) begin
      if (advance) begin
         zero_d_ff[0] <= zero_ff;
         detv_d_ff[0] <= detv_ff;
         for (int s = 1; s < LAT; s++) begin
            zero_d_ff[s] <= zero_d_ff[s-1];
            detv_d_ff[s] <= detv_d_ff[s-1];
         end
      end
   end

   // drop the quotients of a singular matrix
   always_comb begin
      res_w.sing = zero_d_ff[LAT-1];
      res_w.detv = zero_d_ff[LAT-1] ? '0 : detv_d_ff[LAT-1];
      for (int k = 0; k < 9; k++) begin
         res_w.r[k] = zero_d_ff[LAT-1] ? '0 : quo[k];
      end
   end

   // Output register plus skid: while advancing, the item leaving the
   // pipeline goes to the output if it is free or being taken, else to the
   // skid; while held, refill the output from the skid.
   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (advance) begin
         if (!out_v_ff || rsp_chan.ready) begin
            out_in   = res_w;
            out_v_in = div_valid;
         end else begin
            skid_in   = res_w;
            skid_v_in = div_valid;
         end
      end else if (rsp_chan.ready) begin
         out_in    = skid_ff;
         out_v_in  = 1'b1;
         skid_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.r00       = out_ff.r[0];
   assign rsp_chan.r01       = out_ff.r[1];
   assign rsp_chan.r02       = out_ff.r[2];
   assign rsp_chan.r10       = out_ff.r[3];
   assign rsp_chan.r11       = out_ff.r[4];
   assign rsp_chan.r12       = out_ff.r[5];
   assign rsp_chan.r20       = out_ff.r[6];
   assign rsp_chan.r21       = out_ff.r[7];
   assign rsp_chan.r22       = out_ff.r[8];
   assign rsp_chan.det_value = out_ff.detv;
   assign rsp_chan.singular  = out_ff.sing;

endmodule

`default_nettype wire
